@@ rtl/sfgd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the stroke font glyph decoder.
// No dependencies.
package sfgd_pkg;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PEN_UP = 2'd1;
    localparam logic [1:0] KIND_POINT  = 2'd2;
    localparam logic [1:0] KIND_BOX    = 2'd3;

    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_ORIGIN = 8'd82;
    // 'R' plus the baseline offset of 8
    localparam logic signed [8:0] Y_BIAS = 9'sd90;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [8:0] x_coord;
        logic signed [8:0] y_coord;
        logic signed [8:0] glyph_width;
        logic signed [7:0] low_y;
        logic [7:0]        high_y;
        logic [7:0]        widest_glyph;
        logic              last_result;
    } t_result;

endpackage

@@ rtl/stroke_font_glyph_decoder_top.sv @@
`timescale 1ns / 1ps
// Top level of the stroke font glyph decoder.
// Depends on sfgd_pkg, sfgd_decode and sfgd_out_queue.
//
//  Channel  Handshake            Payload
//  input    i_valid / o_ready    i_first_char, i_second_char, i_last_pair
//  result   o_valid / i_ready    o_kind, o_x_coord, o_y_coord, o_glyph_width,
//                                o_low_y, o_high_y, o_widest_glyph, o_last_result
//
// One item per cycle while o_ready is high; its results are written to a
// four-entry queue in that cycle and, if the queue was empty, the first one is
// visible on the next cycle. An item flagged last gives two results, so a steady
// run of them is limited by the single read port of the result queue.
// o_ready is high whenever the queue has room for two results.
// Synchronous active-low reset clears the glyph state and empties the queue.
module stroke_font_glyph_decoder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_first_char,
    input  logic [7:0]        i_second_char,
    input  logic              i_last_pair,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic signed [8:0] o_x_coord,
    output logic signed [8:0] o_y_coord,
    output logic signed [8:0] o_glyph_width,
    output logic signed [7:0] o_low_y,
    output logic [7:0]        o_high_y,
    output logic [7:0]        o_widest_glyph,
    output logic              o_last_result
);
    import sfgd_pkg::*;

    logic    accept;
    logic    two;
    t_result res0;
    t_result res1;
    t_result res_out;

    assign accept = i_valid && o_ready;

    sfgd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_first_char  (i_first_char),
        .i_second_char (i_second_char),
        .i_last_pair   (i_last_pair),
        .o_res0        (res0),
        .o_res1        (res1),
        .o_two         (two)
    );

    sfgd_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_push_two (two),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_space    (o_ready),
        .o_valid    (o_valid),
        .i_pop      (i_ready),
        .o_res      (res_out)
    );

    assign o_kind         = res_out.kind;
    assign o_x_coord      = res_out.x_coord;
    assign o_y_coord      = res_out.y_coord;
    assign o_glyph_width  = res_out.glyph_width;
    assign o_low_y        = res_out.low_y;
    assign o_high_y       = res_out.high_y;
    assign o_widest_glyph = res_out.widest_glyph;
    assign o_last_result  = res_out.last_result;

endmodule

@@ rtl/sfgd_decode.sv @@
`timescale 1ns / 1ps
// Glyph state and per-pair decode: one or two results per accepted item.
// Depends on sfgd_pkg.
module sfgd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_first_char,
    input  logic [7:0]        i_second_char,
    input  logic              i_last_pair,
    output sfgd_pkg::t_result o_res0,
    output sfgd_pkg::t_result o_res1,
    output logic              o_two
);
    import sfgd_pkg::*;

    logic              r_in_glyph;
    logic [7:0]        r_start;
    logic signed [8:0] r_width;
    logic signed [8:0] r_min_y;
    logic signed [8:0] r_max_y;
    logic [7:0]        r_widest;

    logic              n_in_glyph;
    logic [7:0]        n_start;
    logic signed [8:0] n_width;
    logic signed [8:0] n_min_y;
    logic signed [8:0] n_max_y;
    logic [7:0]        n_widest;

    logic signed [8:0] x_val;
    logic signed [8:0] y_val;
    logic              pen_up;

    assign x_val  = $signed({1'b0, i_first_char}) - $signed({1'b0, r_start});
    assign y_val  = $signed({1'b0, i_second_char}) - Y_BIAS;
    assign pen_up = (i_first_char == CH_SPACE) && (i_second_char == CH_ORIGIN);
    assign o_two  = i_last_pair;

    always_comb begin
        n_in_glyph = r_in_glyph;
        n_start    = r_start;
        n_width    = r_width;
        n_min_y    = r_min_y;
        n_max_y    = r_max_y;
        n_widest   = r_widest;
        o_res0     = '0;
        o_res1     = '0;
        o_res0.last_result = ~i_last_pair;

        if (!r_in_glyph) begin
            n_start  = i_first_char;
            n_width  = $signed({1'b0, i_second_char}) - $signed({1'b0, i_first_char});
            n_min_y  = '0;
            n_max_y  = '0;
            o_res0.kind        = KIND_HEADER;
            o_res0.glyph_width = n_width;
        end else if (pen_up) begin
            o_res0.kind = KIND_PEN_UP;
        end else begin
            if (y_val < r_min_y) begin
                n_min_y = y_val;
            end
            if (y_val > r_max_y) begin
                n_max_y = y_val;
            end
            o_res0.kind    = KIND_POINT;
            o_res0.x_coord = x_val;
            o_res0.y_coord = y_val;
        end

        n_in_glyph = ~i_last_pair;
        if (i_last_pair && (n_width > $signed({1'b0, r_widest}))) begin
            n_widest = n_width[7:0];
        end
        o_res1.kind         = KIND_BOX;
        o_res1.glyph_width  = n_width;
        o_res1.low_y        = n_min_y[7:0];
        o_res1.high_y       = n_max_y[7:0];
        o_res1.widest_glyph = n_widest;
        o_res1.last_result  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_glyph <= 1'b0;
            r_start    <= '0;
            r_width    <= '0;
            r_min_y    <= '0;
            r_max_y    <= '0;
            r_widest   <= '0;
        end else if (i_accept) begin
            r_in_glyph <= n_in_glyph;
            r_start    <= n_start;
            r_width    <= n_width;
            r_min_y    <= n_min_y;
            r_max_y    <= n_max_y;
            r_widest   <= n_widest;
        end
    end

    a_min_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_y <= 9'sd0)
        else $error("min y above zero");

    a_max_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_y >= 9'sd0)
        else $error("max y below zero");

    a_widest_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_widest >= $past(r_widest)))
        else $error("widest glyph width dropped");

endmodule

@@ rtl/sfgd_out_queue.sv @@
`timescale 1ns / 1ps
// Small result queue: takes one or two results per cycle, gives one.
// Depends on sfgd_pkg.
module sfgd_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_push_two,
    input  sfgd_pkg::t_result i_res0,
    input  sfgd_pkg::t_result i_res1,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_pop,
    output sfgd_pkg::t_result o_res
);
    import sfgd_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;
    logic [QCNT_W-1:0]   push_cnt;
    logic                pop_ok;

    assign o_valid  = (r_count != '0);
    assign o_space  = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign pop_ok   = i_pop && o_valid;
    assign push_cnt = !i_push ? '0 : (i_push_two ? QCNT_W'(2) : QCNT_W'(1));
    assign n_count  = r_count + push_cnt - QCNT_W'(pop_ok);
    assign o_res    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res0;
            if (i_push_two) begin
                r_mem[r_wr_ptr + QPTR_W'(1)] <= i_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(push_cnt);
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space)
        else $error("push into full result queue");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stroke_font_glyph_decoder_top: a behavioral glyph decoder
// predicts every result of each accepted character pair and a checker compares them.
// Depends on sfgd_pkg and the decoder RTL.
module tb;
    import sfgd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 550;
    localparam int TAIL_CYCLES = 10;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [7:0]        i_first_char = '0;
    logic [7:0]        i_second_char = '0;
    logic              i_last_pair = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [1:0]        o_kind;
    logic signed [8:0] o_x_coord;
    logic signed [8:0] o_y_coord;
    logic signed [8:0] o_glyph_width;
    logic signed [7:0] o_low_y;
    logic [7:0]        o_high_y;
    logic [7:0]        o_widest_glyph;
    logic              o_last_result;

    stroke_font_glyph_decoder_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_first_char   (i_first_char),
        .i_second_char  (i_second_char),
        .i_last_pair    (i_last_pair),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_x_coord      (o_x_coord),
        .o_y_coord      (o_y_coord),
        .o_glyph_width  (o_glyph_width),
        .o_low_y        (o_low_y),
        .o_high_y       (o_high_y),
        .o_widest_glyph (o_widest_glyph),
        .o_last_result  (o_last_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // glyph decoder state
    logic              in_glyph = 1'b0;
    logic [7:0]        start_col = '0;
    logic signed [8:0] glyph_w = '0;
    logic signed [8:0] min_y = '0;
    logic signed [8:0] max_y = '0;
    logic [7:0]        widest_w = '0;

    t_result pending_results[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      results_checked = 0;
    int      boxes_checked = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      stall_cycles = 0;

    function automatic void decode_pair(logic [7:0] a, logic [7:0] b, logic last);
        t_result           r;
        logic signed [8:0] y;
        r = '0;
        if (!in_glyph) begin
            start_col = a;
            glyph_w = $signed({1'b0, b}) - $signed({1'b0, a});
            min_y = '0;
            max_y = '0;
            r.kind = KIND_HEADER;
            r.glyph_width = glyph_w;
            in_glyph = 1'b1;
        end else if (a == CH_SPACE && b == CH_ORIGIN) begin
            r.kind = KIND_PEN_UP;
        end else begin
            y = $signed({1'b0, b}) - Y_BIAS;
            if (y < min_y) min_y = y;
            if (y > max_y) max_y = y;
            r.kind = KIND_POINT;
            r.x_coord = $signed({1'b0, a}) - $signed({1'b0, start_col});
            r.y_coord = y;
        end
        r.last_result = !last;
        pending_results.insert(pending_results.size(), r);
        if (last) begin
            if (glyph_w > $signed({1'b0, widest_w})) widest_w = glyph_w[7:0];
            r = '0;
            r.kind = KIND_BOX;
            r.glyph_width = glyph_w;
            r.low_y = min_y[7:0];
            r.high_y = max_y[7:0];
            r.widest_glyph = widest_w;
            r.last_result = 1'b1;
            pending_results.insert(pending_results.size(), r);
            in_glyph = 1'b0;
        end
    endfunction

    task automatic check_field(string name, logic signed [8:0] expv, logic signed [8:0] actv);
        if (actv !== expv) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        end
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_result exp_r;
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, kind %0d", $time, o_kind);
                end else begin
                    exp_r = pending_results.pop_front();
                    check_field("kind", 9'(exp_r.kind), 9'(o_kind));
                    check_field("x_coord", exp_r.x_coord, o_x_coord);
                    check_field("y_coord", exp_r.y_coord, o_y_coord);
                    check_field("glyph_width", exp_r.glyph_width, o_glyph_width);
                    check_field("low_y", 9'(exp_r.low_y), 9'(o_low_y));
                    check_field("high_y", 9'(exp_r.high_y), 9'(o_high_y));
                    check_field("widest_glyph", 9'(exp_r.widest_glyph), 9'(o_widest_glyph));
                    check_field("last_result", 9'(exp_r.last_result), 9'(o_last_result));
                    results_checked++;
                    if (exp_r.kind == KIND_BOX) boxes_checked++;
                end
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog timeout, %0d results outstanding", $time,
                         pending_results.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_pair(logic [7:0] a, logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_first_char <= a;
        i_second_char <= b;
        i_last_pair <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        decode_pair(a, b, last);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 75) return 8'($urandom_range(60, 110));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_glyph();
        int         n_strokes;
        logic [7:0] start_c;
        logic [7:0] end_c;
        n_strokes = $urandom_range(0, 10);
        start_c = ($urandom_range(99) < 70) ? 8'($urandom_range(60, 90))
                                            : 8'($urandom_range(0, 255));
        if ($urandom_range(99) < 80) end_c = 8'((int'(start_c) + $urandom_range(0, 30)) % 256);
        else end_c = 8'($urandom_range(0, 255));
        send_pair(start_c, end_c, n_strokes == 0);
        for (int i = 1; i <= n_strokes; i++) begin
            if ($urandom_range(99) < 20) send_pair(CH_SPACE, CH_ORIGIN, i == n_strokes);
            else send_pair(pick_char(), pick_char(), i == n_strokes);
        end
    endtask

    task automatic run_random(int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 10)
                send_pair(8'($urandom), 8'($urandom), $urandom_range(3) == 0);
            else
                send_random_glyph();
        end
        wait_for_drain();
    endtask

    task automatic test_header_only();
        send_pair(8'd10, 8'd20, 1'b1);
        send_pair(8'd255, 8'd0, 1'b1);
        send_pair(8'd7, 8'd7, 1'b1);
        send_pair(8'd30, 8'd15, 1'b1);
    endtask

    task automatic test_strokes();
        send_pair(8'd70, 8'd90, 1'b0);
        send_pair(CH_SPACE, CH_ORIGIN, 1'b0);
        send_pair(8'd0, 8'd0, 1'b0);
        send_pair(8'd255, 8'd255, 1'b0);
        send_pair(CH_SPACE, 8'd83, 1'b0);
        send_pair(8'd33, CH_ORIGIN, 1'b0);
        send_pair(8'd128, 8'd127, 1'b0);
        send_pair(CH_SPACE, CH_ORIGIN, 1'b1);
    endtask

    task automatic test_last_stroke();
        send_pair(8'd100, 8'd100, 1'b0);
        send_pair(8'd100, 8'd90, 1'b1);
        send_pair(8'd65, 8'd80, 1'b0);
        send_pair(8'd70, 8'd120, 1'b0);
        send_pair(8'd72, 8'd140, 1'b1);
        send_pair(8'd65, 8'd80, 1'b0);
        send_pair(8'd66, 8'd40, 1'b1);
    endtask

    task automatic test_widest_extremes();
        send_pair(8'd0, 8'd255, 1'b1);
        send_pair(8'd5, 8'd200, 1'b1);
        send_pair(8'd255, 8'd0, 1'b0);
        send_pair(8'd0, 8'd255, 1'b1);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_header_only();
        test_strokes();
        test_last_stroke();
        // hold off until the decoder has emptied out
        wait_for_drain();
        send_idle_pct = 7;
        recv_idle_pct = 62;
        run_random(ITEMS_PER_PHASE);
        send_idle_pct = 62;
        recv_idle_pct = 7;
        run_random(ITEMS_PER_PHASE);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(ITEMS_PER_PHASE);
        test_widest_extremes();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d character pairs; checked %0d results including %0d glyph boxes",
                 items_sent, results_checked, boxes_checked);
        $display("under three sender/receiver stall mixes, %0d mismatches", mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d results never arrived", pending_results.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ stroke_font_glyph_decoder_top.f @@
rtl/sfgd_pkg.sv
rtl/sfgd_decode.sv
rtl/sfgd_out_queue.sv
rtl/stroke_font_glyph_decoder_top.sv
dv/tb.sv
